// ===== src/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants for the indexed list store: request and result
// payloads, opcodes, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ilir_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths of the request and result
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Position code that means "append at the end" on insert (-1)
  localparam logic [POS_W-1:0] POS_APPEND = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_READ       = 3'd0,
    OP_INSERT     = 3'd1,
    OP_WRITE      = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_REMOVE_VAL = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic signed [POS_W-1:0]  position;
    logic [DATA_W-1:0]        entry_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_value;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  // Pointer load sources
  typedef enum logic [1:0] {
    PTR_TGT,
    PTR_TGT_INC,
    PTR_LAST,
    PTR_ZERO
  } ptr_sel_e;

  // Sweep end sources
  typedef enum logic {
    END_TGT,
    END_LAST
  } end_sel_e;

  // Target index sources: request position, insert slot, last read address
  typedef enum logic [1:0] {
    TGT_POS,
    TGT_INS,
    TGT_LAG
  } tgt_sel_e;

  // Write address sources
  typedef enum logic [1:0] {
    WA_TGT,
    WA_UP,
    WA_DOWN
  } wa_sel_e;

  typedef struct packed {
    logic     req_load;
    tgt_sel_e tgt_sel;
    logic     ptr_load;
    ptr_sel_e ptr_sel;
    logic     ptr_step;
    logic     ptr_up;
    logic     end_load;
    end_sel_e end_sel;
    logic     wr_en;
    wa_sel_e  wa_sel;
    logic     wd_rd;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     fin;
    status_e  fin_status;
    logic     fin_rd;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    in_range;
    logic    ins_bad;
    logic    full;
    logic    ins_tail;
    logic    tgt_last;
    logic    empty;
    logic    ptr_end;
    logic    match;
  } dp_stat_t;

endpackage

// ===== src/ilir_dp.sv =====
// ----------------------------------------------------------------------------
// ilir_dp
// Datapath: entry memory, count, sweep pointer, request and result registers.
// ----------------------------------------------------------------------------
module ilir_dp #(
  parameter int CAPACITY   = ilir_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ilir_pkg::VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ilir_pkg::req_t    req_i,
  input  ilir_pkg::dp_cmd_t cmd_i,
  output ilir_pkg::dp_stat_t stat_o,
  output ilir_pkg::rsp_t    rsp_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ilir_pkg::POS_W;
  localparam int MW = (CW > PW) ? CW : PW;
  localparam int DW = ilir_pkg::DATA_W;
  localparam int NW = ilir_pkg::COUNT_W;
  localparam int LW = (VALUE_BITS < DW) ? VALUE_BITS : DW;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  ilir_pkg::opcode_e     op_q;
  logic [PW-1:0]         pos_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [IW-1:0]         ptr_q, ptr_d;
  logic [IW-1:0]         end_q, end_d;
  logic [IW-1:0]         lag_q;
  logic [VALUE_BITS-1:0] rd_q;
  ilir_pkg::rsp_t        rsp_q;

  logic [MW-1:0]         pos_w, cnt_w;
  logic [IW-1:0]         pos_idx, cnt_idx, last_idx, tgt, wa;
  logic [CW-1:0]         cnt_m1;
  logic                  append;
  logic [VALUE_BITS-1:0] wd;

  always_comb begin
    pos_w    = MW'(pos_q);
    cnt_w    = MW'(cnt_q);
    pos_idx  = pos_w[IW-1:0];
    cnt_idx  = cnt_q[IW-1:0];
    cnt_m1   = cnt_q - CW'(1);
    last_idx = cnt_m1[IW-1:0];
    append   = (pos_q == ilir_pkg::POS_APPEND);

    case (cmd_i.tgt_sel)
      ilir_pkg::TGT_POS: tgt = pos_idx;
      ilir_pkg::TGT_INS: tgt = append ? cnt_idx : pos_idx;
      ilir_pkg::TGT_LAG: tgt = lag_q;
      default:           tgt = pos_idx;
    endcase

    case (cmd_i.wa_sel)
      ilir_pkg::WA_TGT:  wa = tgt;
      ilir_pkg::WA_UP:   wa = lag_q + IW'(1);
      ilir_pkg::WA_DOWN: wa = lag_q - IW'(1);
      default:           wa = tgt;
    endcase
    wd = cmd_i.wd_rd ? rd_q : val_q;

    ptr_d = ptr_q;
    if (cmd_i.ptr_load) begin
      case (cmd_i.ptr_sel)
        ilir_pkg::PTR_TGT:     ptr_d = tgt;
        ilir_pkg::PTR_TGT_INC: ptr_d = tgt + IW'(1);
        ilir_pkg::PTR_LAST:    ptr_d = last_idx;
        ilir_pkg::PTR_ZERO:    ptr_d = '0;
        default:               ptr_d = '0;
      endcase
    end else if (cmd_i.ptr_step) begin
      ptr_d = cmd_i.ptr_up ? ptr_q + IW'(1) : ptr_q - IW'(1);
    end

    end_d = end_q;
    if (cmd_i.end_load) begin
      end_d = (cmd_i.end_sel == ilir_pkg::END_LAST) ? last_idx : tgt;
    end

    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_m1;
    end

    stat_o.op       = op_q;
    stat_o.in_range = !pos_q[PW-1] && (pos_w < cnt_w);
    stat_o.ins_bad  = pos_q[PW-1] ? !append : (pos_w > cnt_w);
    stat_o.full     = (cnt_q == CAP_CNT);
    stat_o.ins_tail = append || (pos_w == cnt_w);
    stat_o.tgt_last = (CW'(tgt) == cnt_m1);
    stat_o.empty    = (cnt_q == '0);
    stat_o.ptr_end  = (ptr_q == end_q);
    stat_o.match    = (rd_q == val_q);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
      end_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      end_q <= end_d;
    end
  end

  // Request, read pipeline and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      op_q  <= ilir_pkg::opcode_e'(req_i.opcode);
      pos_q <= req_i.position;
      val_q <= VALUE_BITS'(req_i.entry_value[LW-1:0]);
    end
    lag_q <= ptr_q;
    if (cmd_i.fin) begin
      rsp_q.status      <= cmd_i.fin_status;
      rsp_q.read_value  <= cmd_i.fin_rd ? DW'(rd_q) : '0;
      rsp_q.entry_count <= NW'(cnt_q);
    end
  end

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ptr_q];
  end

  assign rsp_o = rsp_q;

endmodule

// ===== src/ilir_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilir_ctrl
// Controller: sequences range checks, shift sweeps and value search.
// ----------------------------------------------------------------------------
module ilir_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  ilir_pkg::dp_stat_t stat_i,
  output ilir_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_RD_WAIT,
    S_SH_FIRST,
    S_SH_RUN,
    S_SH_LAST,
    S_PUT,
    S_SR_FIRST,
    S_SR_RUN,
    S_SR_LAST,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  ilir_pkg::status_e sts_q, sts_d;
  logic              rdf_q, rdf_d;
  logic              done_q, done_d;

  always_comb begin
    state_d = state_q;
    sts_d   = sts_q;
    rdf_d   = rdf_q;
    done_d  = 1'b0;

    cmd_o            = '0;
    cmd_o.tgt_sel    = ilir_pkg::TGT_POS;
    cmd_o.ptr_sel    = ilir_pkg::PTR_ZERO;
    cmd_o.end_sel    = ilir_pkg::END_LAST;
    cmd_o.fin_status = sts_q;
    // inserts sweep downward and write one above; removes the reverse
    cmd_o.ptr_up     = (stat_i.op != ilir_pkg::OP_INSERT);
    cmd_o.wa_sel     = cmd_o.ptr_up ? ilir_pkg::WA_DOWN : ilir_pkg::WA_UP;
    cmd_o.wd_rd      = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.req_load = 1'b1;
          sts_d          = ilir_pkg::ST_OK;
          rdf_d          = 1'b0;
          state_d        = S_EVAL;
        end
      end

      S_EVAL: begin
        state_d = S_FIN;
        case (stat_i.op)
          ilir_pkg::OP_READ: begin
            if (stat_i.in_range) begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = ilir_pkg::PTR_TGT;
              rdf_d          = 1'b1;
              state_d        = S_RD_WAIT;
            end else begin
              sts_d = ilir_pkg::ST_RANGE;
            end
          end
          ilir_pkg::OP_INSERT: begin
            cmd_o.tgt_sel = ilir_pkg::TGT_INS;
            if (stat_i.ins_bad) begin
              sts_d = ilir_pkg::ST_RANGE;
            end else if (stat_i.full) begin
              sts_d = ilir_pkg::ST_FULL;
            end else if (stat_i.ins_tail) begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wa_sel  = ilir_pkg::WA_TGT;
              cmd_o.wd_rd   = 1'b0;
              cmd_o.cnt_inc = 1'b1;
            end else begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = ilir_pkg::PTR_LAST;
              cmd_o.end_load = 1'b1;
              cmd_o.end_sel  = ilir_pkg::END_TGT;
              state_d        = S_SH_FIRST;
            end
          end
          ilir_pkg::OP_WRITE: begin
            if (stat_i.in_range) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wa_sel = ilir_pkg::WA_TGT;
              cmd_o.wd_rd  = 1'b0;
            end else begin
              sts_d = ilir_pkg::ST_RANGE;
            end
          end
          ilir_pkg::OP_REMOVE: begin
            if (!stat_i.in_range) begin
              sts_d = ilir_pkg::ST_RANGE;
            end else if (stat_i.tgt_last) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = ilir_pkg::PTR_TGT_INC;
              cmd_o.end_load = 1'b1;
              state_d        = S_SH_FIRST;
            end
          end
          ilir_pkg::OP_REMOVE_VAL: begin
            if (stat_i.empty) begin
              sts_d = ilir_pkg::ST_MISSING;
            end else begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.end_load = 1'b1;
              state_d        = S_SR_FIRST;
            end
          end
          default: ;
        endcase
      end

      S_RD_WAIT: begin
        state_d = S_FIN;
      end

      // shift sweep: read at ptr, write previous read one slot over
      S_SH_FIRST: begin
        if (stat_i.ptr_end) begin
          state_d = S_SH_LAST;
        end else begin
          cmd_o.ptr_step = 1'b1;
          state_d        = S_SH_RUN;
        end
      end

      S_SH_RUN: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.ptr_end) begin
          state_d = S_SH_LAST;
        end else begin
          cmd_o.ptr_step = 1'b1;
        end
      end

      S_SH_LAST: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.op == ilir_pkg::OP_INSERT) begin
          state_d = S_PUT;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FIN;
        end
      end

      S_PUT: begin
        cmd_o.tgt_sel = ilir_pkg::TGT_INS;
        cmd_o.wr_en   = 1'b1;
        cmd_o.wa_sel  = ilir_pkg::WA_TGT;
        cmd_o.wd_rd   = 1'b0;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_FIN;
      end

      S_SR_FIRST: begin
        if (stat_i.ptr_end) begin
          state_d = S_SR_LAST;
        end else begin
          cmd_o.ptr_step = 1'b1;
          state_d        = S_SR_RUN;
        end
      end

      S_SR_RUN, S_SR_LAST: begin
        cmd_o.tgt_sel = ilir_pkg::TGT_LAG;
        if (stat_i.match) begin
          // first hit: remove at the compared index
          if (stat_i.tgt_last) begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_FIN;
          end else begin
            cmd_o.ptr_load = 1'b1;
            cmd_o.ptr_sel  = ilir_pkg::PTR_TGT_INC;
            cmd_o.end_load = 1'b1;
            state_d        = S_SH_FIRST;
          end
        end else if (state_q == S_SR_LAST) begin
          sts_d   = ilir_pkg::ST_MISSING;
          state_d = S_FIN;
        end else if (stat_i.ptr_end) begin
          state_d = S_SR_LAST;
        end else begin
          cmd_o.ptr_step = 1'b1;
        end
      end

      S_FIN: begin
        cmd_o.fin    = 1'b1;
        cmd_o.fin_rd = rdf_q;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sts_q   <= ilir_pkg::ST_OK;
      rdf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sts_q   <= sts_d;
      rdf_q   <= rdf_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== src/indexed_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Ordered list of up to CAPACITY entries with read, insert, overwrite,
// remove at index and remove by value.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request on req_i is taken at a rising edge where start
//   is high and busy is low. busy stays high while the request is worked on.
//   Result channel: done_o is high for exactly one cycle with rsp_o holding
//   status, read value and entry count; the receiver must take it then.
// Sequencing: read, overwrite, append and range or full rejects need no sweep;
//   insert at index shifts the entries above it up, then writes the new entry;
//   remove at index shifts the entries above it down; remove by value
//   searches, then shifts. The shift and search sweeps move one entry per cycle
//   through the single write port and registered read port of the entry memory.
// A new request can be taken in the same cycle that done_o is high.
// Reset: count goes to zero. The entry memory is not cleared: entries at or
//   above the count are never read, so no clearing pass is needed and the
//   block takes requests right after reset.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
  parameter int CAPACITY   = ilir_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ilir_pkg::VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ilir_pkg::req_t req_i,
  output logic           done_o,
  output ilir_pkg::rsp_t rsp_o
);

  ilir_pkg::dp_cmd_t  cmd;
  ilir_pkg::dp_stat_t stat;

  // Sequencer: checks, sweep control, status choice
  ilir_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Entry memory, count, sweep pointer and result register
  ilir_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

endmodule

// ===== src/ilir_checker.sv =====
// ----------------------------------------------------------------------------
// ilir_checker
// Port-level checks for the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
module ilir_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input ilir_pkg::rsp_t rsp_o
);

  // accepted request keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // result shows as the block goes idle
  a_done_on_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe outside end of request");

  // one result per request: never two strobes in a row
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  // failed requests return no data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != ilir_pkg::ST_OK) |-> (rsp_o.read_value == '0))
    else $error("read value nonzero on failed request");

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed list store. A shadow list predicts every
// result. A driver issues queued requests, and a monitor checks each done_o
// strobe, field by field, against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
  import ilir_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 600000;
  // Wait well past the longest request at the end.
  localparam int TAIL_CYCLES = 100;

  // Opcodes outside the enum; the block ignores them but still answers.
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

  // Shadow copy of the list: entry store plus count.
  typedef struct {
    logic [DATA_W-1:0] ent [CAPACITY];
    int                cnt;
  } list_t;

  // One queued request with its sender-side pacing.
  typedef struct {
    req_t        req;
    int unsigned idle_pct;    // chance in 100 that the sender idles per cycle
    bit          drain_first; // hold the request until nothing is outstanding
  } pend_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req    = '0;
  logic done;
  rsp_t rsp;

  pend_t pending_reqs  [$];
  rsp_t  expected_rsps [$];
  list_t model_list;  // follows accepted requests
  list_t plan_list;   // follows generated requests, steers the stimulus

  int n_issued  = 0;  // requests accepted (driver, nonblocking)
  int n_checked = 0;  // results taken (monitor, nonblocking)
  int errors    = 0;
  int cycles    = 0;

  indexed_list_insert_remove u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow list
  // --------------------------------------------------------------------------
  function automatic list_t list_clear();
    list_t l;
    for (int i = 0; i < CAPACITY; i++) l.ent[i] = '0;
    l.cnt = 0;
    return l;
  endfunction

  // Close the gap at idx; the vacated last slot reads back as zero.
  function automatic void list_close_gap(inout list_t l, input int idx);
    for (int i = idx + 1; i < l.cnt; i++) l.ent[i-1] = l.ent[i];
    l.cnt--;
    l.ent[l.cnt] = '0;
  endfunction

  // Apply one request to a list and return the result it yields.
  function automatic rsp_t list_apply(inout list_t l, input req_t r);
    rsp_t o;
    int   pos;
    int   at;
    bit   in_range;
    o        = '0;
    pos      = int'($signed(r.position));
    in_range = (pos >= 0) && (pos < l.cnt);
    o.status = ST_OK;
    case (r.opcode)
      OP_READ: begin
        if (in_range) o.read_value = l.ent[pos];
        else o.status = ST_RANGE;
      end
      OP_INSERT: begin
        // Bad position is reported ahead of a full list.
        if (pos < -1 || pos > l.cnt) begin
          o.status = ST_RANGE;
        end else if (l.cnt >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          at = (pos == -1) ? l.cnt : pos;
          for (int i = l.cnt; i > at; i--) l.ent[i] = l.ent[i-1];
          l.ent[at] = r.entry_value;
          l.cnt++;
        end
      end
      OP_WRITE: begin
        if (in_range) l.ent[pos] = r.entry_value;
        else o.status = ST_RANGE;
      end
      OP_REMOVE: begin
        if (in_range) list_close_gap(l, pos);
        else o.status = ST_RANGE;
      end
      OP_REMOVE_VAL: begin
        // Only the first match goes.
        o.status = ST_MISSING;
        for (int i = 0; i < l.cnt; i++) begin
          if (l.ent[i] == r.entry_value) begin
            list_close_gap(l, i);
            o.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    o.entry_count = l.cnt[COUNT_W-1:0];
    return o;
  endfunction

  task automatic add_req(input logic [OPCODE_W-1:0] op, input int pos,
                         input logic [DATA_W-1:0] val, input int unsigned idle_pct,
                         input bit drain_first);
    pend_t p;
    p.req.opcode      = op;
    p.req.position    = pos[POS_W-1:0];
    p.req.entry_value = val;
    p.idle_pct        = idle_pct;
    p.drain_first     = drain_first;
    void'(list_apply(plan_list, p.req));
    pending_reqs.push_back(p);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: a request is taken at an edge with start high and busy low. start
  // stays up while busy; once taken, the next request may follow at once.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    bit took;
    int outstanding;
    took = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsps.push_back(list_apply(model_list, pending_reqs[0].req));
        pending_reqs.delete(0);
        took = 1'b1;
      end
      // Both counters are nonblocking, so this is independent of the monitor.
      outstanding = n_issued + int'(took) - n_checked - int'(done);
      n_issued <= n_issued + int'(took);
      if (start && busy) begin
        // hold the request until it is taken
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && outstanding != 0) &&
                   $urandom_range(99) >= pending_reqs[0].idle_pct) begin
        start <= 1'b1;
        req   <= pending_reqs[0].req;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each done_o strobe is one result, taken at the edge ending it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    rsp_t exp_rsp;
    if (rst_ni && done) begin
      if (n_issued == n_checked) begin
        $display("%0t: result with nothing expected: status %0d value 0x%0h count %0d",
                 $time, rsp.status, rsp.read_value, rsp.entry_count);
        errors++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        check_field("status", DATA_W'(exp_rsp.status), DATA_W'(rsp.status));
        check_field("read_value", exp_rsp.read_value, rsp.read_value);
        check_field("entry_count", DATA_W'(exp_rsp.entry_count), DATA_W'(rsp.entry_count));
        n_checked <= n_checked + 1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d requests still expected", $time, n_issued - n_checked);
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                  seg_left;
    int                  seg_mode;  // 0 fill, 1 drain, 2 mixed
    int                  r;
    int                  k;
    int                  pos;
    int unsigned         idle;
    bit                  drain;
    logic [OPCODE_W-1:0] op;
    logic [DATA_W-1:0]   val;

    model_list = list_clear();
    plan_list  = list_clear();

    // Directed: empty-list rejects, bad insert positions, every opcode.
    add_req(OP_READ,       0,    32'h0,        0, 1'b0);  // read empty
    add_req(OP_REMOVE_VAL, 0,    32'h0,        0, 1'b0);  // value absent, empty
    add_req(OP_REMOVE,     0,    32'h0,        0, 1'b0);  // remove empty
    add_req(OP_WRITE,      -1,   32'h1,        0, 1'b0);  // negative overwrite
    add_req(OP_INSERT,     1,    32'h1,        0, 1'b0);  // past count
    add_req(OP_INSERT,     -2,   32'h1,        0, 1'b0);  // below append code
    add_req(OP_INSERT,     -1,   32'hFFFF_FFFF, 0, 1'b0); // append
    add_req(OP_INSERT,     0,    32'h0,        0, 1'b0);  // head
    add_req(OP_INSERT,     2,    32'h8000_0001, 0, 1'b0); // at count
    add_req(OP_INSERT,     1,    32'h1234_5678, 0, 1'b0); // middle
    add_req(OP_INSERT,     127,  32'h5,        0, 1'b0);
    add_req(OP_INSERT,     -128, 32'h5,        0, 1'b0);
    add_req(OP_READ,       3,    32'h0,        0, 1'b0);  // last entry
    add_req(OP_READ,       4,    32'h0,        0, 1'b0);  // at count
    add_req(OP_READ,       -128, 32'h0,        0, 1'b0);
    add_req(OP_WRITE,      0,    32'hAAAA_AAAA, 0, 1'b0);
    add_req(OP_WRITE,      4,    32'h5555_5555, 0, 1'b0); // at count
    add_req(OP_INSERT,     -1,   32'h1234_5678, 0, 1'b0); // duplicate value
    add_req(OP_REMOVE_VAL, 0,    32'h1234_5678, 0, 1'b0); // first match only
    add_req(OP_REMOVE_VAL, 0,    32'h5555_5555, 0, 1'b0); // absent
    add_req(OP_REMOVE,     2,    32'h0,        0, 1'b0);  // next to last
    add_req(OP_REMOVE,     0,    32'h0,        0, 1'b0);  // first
    for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++)
      add_req(u[OPCODE_W-1:0], $urandom_range(255), $urandom, 0, 1'b0);

    // Random: segments that fill, drain or mix, so the list sweeps from
    // empty to full and back with valid positions most of the time.
    seg_mode = 0;
    seg_left = 160;
    for (int n = 0; n < 1100; n++) begin
      k = pending_reqs.size();
      if (seg_left == 0) begin
        seg_mode = $urandom_range(2);
        seg_left = $urandom_range(60, 160);
      end
      seg_left--;

      r = $urandom_range(99);
      if (r < 3) begin
        op = OP_UNUSED_LO + 3'($urandom_range(2));
      end else begin
        r = $urandom_range(99);
        case (seg_mode)
          0:       op = (r < 60) ? OP_INSERT : (r < 70) ? OP_READ : (r < 80) ? OP_WRITE :
                        (r < 90) ? OP_REMOVE : OP_REMOVE_VAL;
          1:       op = (r < 15) ? OP_INSERT : (r < 30) ? OP_READ : (r < 40) ? OP_WRITE :
                        (r < 70) ? OP_REMOVE : OP_REMOVE_VAL;
          default: op = (r < 30) ? OP_INSERT : (r < 50) ? OP_READ : (r < 65) ? OP_WRITE :
                        (r < 80) ? OP_REMOVE : OP_REMOVE_VAL;
        endcase
      end

      r = $urandom_range(99);
      if (r < 10) begin
        pos = $urandom_range(255);             // any code, mostly out of range
      end else if (r < 15) begin
        pos = plan_list.cnt;                   // just past the end
      end else if (op == OP_INSERT) begin
        pos = ($urandom_range(3) == 0) ? -1 : $urandom_range(plan_list.cnt);
      end else begin
        pos = (plan_list.cnt == 0) ? 0 : $urandom_range(plan_list.cnt - 1);
      end

      r = $urandom_range(99);
      if (op == OP_REMOVE_VAL && plan_list.cnt != 0 && r < 70)
        val = plan_list.ent[$urandom_range(plan_list.cnt - 1)];
      else if (r < 85)
        val = $urandom_range(7);               // small values make duplicates
      else if (r < 90)
        val = {DATA_W{r[0]}};
      else
        val = $urandom;

      // Pacing phases: none, sender mostly idle, none, sender idle a quarter.
      idle  = (k < 300) ? 0 : (k < 600) ? 79 : (k < 850) ? 0 : 26;
      drain = (k == 100 || k == 450 || k == 700 || k == 1000);
      add_req(op, pos, val, idle, drain);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || start || n_checked != n_issued) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_rsps.size() != 0)
      $display("%0t: %0d expected results never came", $time, expected_rsps.size());
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
